// ===== sv/assert_macros.svh =====
// Assertion macros included by the quarter-round unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on the same edge.
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Implication checked on the next edge.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== sv/chqr_pkg.sv =====
// Types, constants and helpers for the quarter-round functional unit.
package chqr_pkg;

  localparam int unsigned FuncW = 3;
  localparam int unsigned XlenW = 64;
  localparam int unsigned WordW = 32;

  localparam int unsigned RotA = 16;
  localparam int unsigned RotB = 12;
  localparam int unsigned RotC = 8;
  localparam int unsigned RotD = 24;
  localparam int unsigned RotE = 7;

  typedef logic [WordW-1:0] word_t;
  typedef logic [XlenW-1:0] xlen_t;

  typedef enum logic [FuncW-1:0] {
    FUNC_PACK   = 3'd0,
    FUNC_PACKH  = 3'd1,
    FUNC_PACKHL = 3'd2,
    FUNC_QBD    = 3'd3,
    FUNC_QAD    = 3'd4,
    FUNC_QBC    = 3'd5
  } func_e;

  // Rotate left by a constant amount between 1 and WordW-1.
  function automatic word_t rotl(input word_t v, input int unsigned s);
    rotl = (v << s) | (v >> (WordW - s));
  endfunction

endpackage

// ===== sv/chqr_alu.sv =====
// Combinational datapath: half-word packing and the three quarter-round steps.
module chqr_alu (
  input  logic [chqr_pkg::FuncW-1:0] func_i,
  input  chqr_pkg::xlen_t            src_one_i,
  input  chqr_pkg::xlen_t            src_two_i,
  output chqr_pkg::xlen_t            result_o
);
  import chqr_pkg::*;

  word_t one_hi, one_lo, two_hi, two_lo;
  word_t bd_id, bd_ib;
  word_t ad_na, ad_nd;
  word_t bc_t, bc_nc, bc_nb;

  assign one_hi = src_one_i[XlenW-1:WordW];
  assign one_lo = src_one_i[WordW-1:0];
  assign two_hi = src_two_i[XlenW-1:WordW];
  assign two_lo = src_two_i[WordW-1:0];

  // src_one = {a, d}, src_two = {b, c}
  assign bd_id = rotl((one_hi + two_hi) ^ one_lo, RotA);
  assign bd_ib = rotl((two_lo + bd_id) ^ two_hi, RotB);

  // src_one = {a, d}, src_two = {ib, id}
  assign ad_na = two_hi + (rotl(two_lo, RotA) ^ one_lo);
  assign ad_nd = rotl(two_lo ^ ad_na, RotC);

  // src_one = {b, c}, src_two = {na, nd}
  assign bc_t  = one_lo + (rotl(two_lo, RotD) ^ two_hi);
  assign bc_nc = bc_t + two_lo;
  assign bc_nb = rotl(bc_nc ^ rotl(one_hi ^ bc_t, RotB), RotE);

  always_comb begin
    case (func_e'(func_i))
      FUNC_PACK:   result_o = {two_lo, one_lo};
      FUNC_PACKH:  result_o = {two_hi, one_hi};
      FUNC_PACKHL: result_o = {two_hi, one_lo};
      FUNC_QBD:    result_o = {bd_ib, bd_id};
      FUNC_QAD:    result_o = {ad_na, ad_nd};
      FUNC_QBC:    result_o = {bc_nb, bc_nc};
      default:     result_o = '0;
    endcase
  end

endmodule

// ===== sv/chacha_quarter_round_ise_unit.sv =====
// A result appears on dest_value_o with done_o after the operand and result registers.
// Throughput: one transfer per cycle; busy stays low since the input register
// and the result register form a fixed two-stage pipe around the datapath.
// The receiver cannot stall: every result is shown for exactly one cycle.
// Reset (asynchronous, active low) clears both stage valid flags; no other state.
module chacha_quarter_round_ise_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [chqr_pkg::FuncW-1:0] func_i,
  input  chqr_pkg::xlen_t            src_one_i,
  input  chqr_pkg::xlen_t            src_two_i,
  output logic                       done_o,
  output chqr_pkg::xlen_t            dest_value_o
);
  import chqr_pkg::*;

  logic             op_valid_q, done_q;
  logic [FuncW-1:0] func_q;
  xlen_t            src_one_q, src_two_q;
  xlen_t            result_d, result_q;
  logic             accept;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_valid_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      op_valid_q <= accept;
      done_q     <= op_valid_q;
    end
  end

  // Operand register: load on transfer only.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q    <= func_i;
      src_one_q <= src_one_i;
      src_two_q <= src_two_i;
    end
  end

  chqr_alu u_alu (
    .func_i    (func_q),
    .src_one_i (src_one_q),
    .src_two_i (src_two_q),
    .result_o  (result_d)
  );

  always_ff @(posedge clk_i) begin
    if (op_valid_q) begin
      result_q <= result_d;
    end
  end

  assign done_o       = done_q;
  assign dest_value_o = result_q;

  `include "assert_macros.svh"

  `ASSERT_NEXT(a_accept_to_op, start, op_valid_q)
  `ASSERT_NEXT(a_op_to_done, op_valid_q, done_o)
  `ASSERT_NEXT(a_no_spurious_done, !op_valid_q, !done_o)
  `ASSERT_NEXT(a_unused_zero, op_valid_q && (func_q > FUNC_QBC), dest_value_o == '0)
  `ASSERT_SAME(a_never_busy, 1'b1, !busy)

endmodule
